/* rtl/core/pcfc_pkg.sv */
`timescale 1ns / 1ps

package pcfc_pkg;

    // CRC-16 constants: MSB-first, polynomial 0x1021, no reflection, no final XOR.
    localparam logic [15:0] CrcPoly     = 16'h1021;
    localparam logic [15:0] CrcSeedRst  = 16'hFFFF;

    // Packet layout: type, address, length, flags, CRC low, CRC high, then payload.
    localparam int unsigned HeaderBytes = 6;
    localparam int unsigned PosWidth    = 9;
    localparam logic [PosWidth-1:0] PosKind    = 9'd0;
    localparam logic [PosWidth-1:0] PosAddr    = 9'd1;
    localparam logic [PosWidth-1:0] PosLength  = 9'd2;
    localparam logic [PosWidth-1:0] PosCrcLow  = 9'd4;
    localparam logic [PosWidth-1:0] PosCrcHigh = 9'd5;
    localparam logic [PosWidth-1:0] PosPayload = 9'd6;
    // The last two payload bytes are consumed but not covered.
    localparam logic [PosWidth-1:0] CoverSkew  = 9'd4;
    localparam logic [PosWidth-1:0] PosMax     = 9'd260;

    // Output beat layout.
    localparam int unsigned OutDataWidth = 56;

    // One byte through the CRC, eight shift steps unrolled.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/packet_crc16_frame_checker_unit.sv */
`timescale 1ns / 1ps

// Packet CRC-16 frame checker. Bytes of a packet (six header bytes: type,
// address, length, flags, CRC low, CRC high, then "length" payload bytes)
// arrive one per beat on the slave side. A CRC-16 (polynomial 0x1021,
// MSB first) starts from the seed register at the first byte of each packet
// and covers the first four header bytes and all payload bytes but the last
// two. On the last byte of a packet one beat is sent on the master side with
// the computed and received CRC, the type, address and length fields and a
// match flag; other bytes produce no beat. The block takes one byte every
// cycle while the master side does not stall; a result beat passes through
// one input register and one result register around a single eight-bit CRC
// update. The seed is written through i_cfg_we and takes effect from the
// next packet.
module packet_crc16_frame_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: CRC seed.
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // Slave side.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // Master side.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [pcfc_pkg::OutDataWidth-1:0] o_m_tdata,
    // [15:0] computed_crc, [31:16] received_crc, [39:32] packet_kind,
    // [47:40] module_address, [55:48] payload_count
    output logic [0:0]  o_m_tuser    // [0] crc_ok
);
    import pcfc_pkg::*;

    logic [15:0]         r_seed;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic [PosWidth-1:0] r_pos;
    logic [15:0]         r_crc;
    logic [7:0]          r_len;
    logic [15:0]         r_rx_crc;
    logic [7:0]          r_kind;
    logic [7:0]          r_addr;
    logic                r_out_valid;
    logic [OutDataWidth-1:0] r_out_data;
    logic                r_out_ok;

    logic                out_free;
    logic                advance;
    logic [15:0]         crc_base;
    logic                covered;
    logic [15:0]         n_crc;
    logic [15:0]         n_rx_crc;
    logic [7:0]          n_kind;
    logic [7:0]          n_addr;
    logic [7:0]          n_len;
    logic                last;
    logic [PosWidth-1:0] n_pos;

    // Handshake: the byte register moves on whenever the result register can take a beat.
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= CrcSeedRst;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // Per-byte processing: CRC update, header capture and end-of-packet detection.
    always_comb begin
        crc_base = (r_pos == PosKind) ? r_seed : r_crc;
        n_kind   = r_kind;
        n_addr   = r_addr;
        n_len    = r_len;
        n_rx_crc = r_rx_crc;
        covered  = 1'b0;
        if (r_pos < PosCrcLow) begin
            covered = 1'b1;
        end else if (r_pos >= PosPayload) begin
            covered = (r_pos - CoverSkew) < {1'b0, r_len};
        end
        if (r_pos == PosKind) begin
            n_kind = r_in_byte;
        end
        if (r_pos == PosAddr) begin
            n_addr = r_in_byte;
        end
        if (r_pos == PosLength) begin
            n_len = r_in_byte;
        end
        if (r_pos == PosCrcLow) begin
            n_rx_crc = {r_rx_crc[15:8], r_in_byte};
        end
        if (r_pos == PosCrcHigh) begin
            n_rx_crc = {r_in_byte, r_rx_crc[7:0]};
        end
        n_crc = covered ? crc_byte(crc_base, r_in_byte) : crc_base;
        last  = (r_pos >= PosCrcHigh) && (r_pos == (PosCrcHigh + {1'b0, r_len}));
        n_pos = last ? PosKind : (r_pos + 9'd1);
    end

    // Packet state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= PosKind;
            r_crc    <= CrcSeedRst;
            r_len    <= 8'd0;
            r_rx_crc <= 16'd0;
            r_kind   <= 8'd0;
            r_addr   <= 8'd0;
        end else if (advance) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_len    <= n_len;
            r_rx_crc <= n_rx_crc;
            r_kind   <= n_kind;
            r_addr   <= n_addr;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && last) begin
            r_out_data <= {n_len, n_addr, n_kind, n_rx_crc, n_crc};
            r_out_ok   <= (n_crc == n_rx_crc);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_ok;

`ifndef SYNTHESIS
    // The byte position never runs past the end of the longest packet.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PosMax)
        else $error("byte position out of range");

    // A finished packet yields a result beat and restarts at the first header byte.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && last) |=> (o_m_tvalid && (r_pos == PosKind)))
        else $error("result not presented after last byte");

    // The match flag agrees with the two CRC fields of the beat.
    a_flag_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] == (o_m_tdata[15:0] == o_m_tdata[31:16])))
        else $error("crc_ok disagrees with CRC fields");

    // A held byte is not overwritten while the result side stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input byte lost under stall");
`endif

endmodule
